FILE: hdl/afpd_pkg.sv
package afpd_pkg;

  localparam int WIN_DEPTH = 4;

  localparam int SMP_W  = 15;
  localparam int THR_W  = 15;
  localparam int RUN_W  = 8;
  localparam int CNT_W  = $clog2(WIN_DEPTH + 1);
  localparam int SLOT_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int SUM_W  = SMP_W + CNT_W;
  localparam int MAG_W  = SUM_W - 1;
  localparam int AVG_W  = SMP_W;
  localparam int SQ_W   = 2 * AVG_W;
  localparam int RAD_W  = SQ_W;
  localparam int ROOT_W = RAD_W / 2;

  localparam int DIV_STEP_W  = $clog2(MAG_W);
  localparam int ROOT_REM_W  = ROOT_W + 2;
  localparam int ROOT_STEP_W = $clog2(ROOT_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_LIFTOFF_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZG_CEIL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENT_THR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAT_THR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAT_LIMIT  = 3'd5;

  localparam logic [THR_W-1:0] RST_LIFTOFF_THR = 15'd1150;
  localparam logic [THR_W-1:0] RST_ZG_CEIL     = 15'd200;
  localparam logic [THR_W-1:0] RST_DESCENT_THR = 15'd1200;
  localparam logic [RUN_W-1:0] RST_SUSTAIN     = 8'd3;
  localparam logic [THR_W-1:0] RST_FLAT_THR    = 15'd50;
  localparam logic [RUN_W-1:0] RST_FLAT_LIMIT  = 8'd10;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_LIFTOFF = 2'd1;
  localparam logic [1:0] EV_ZERO_G  = 2'd2;
  localparam logic [1:0] EV_DESCENT = 2'd3;

  typedef struct packed {
    logic              start;
    logic              full;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  divisor;
  } lane_ctrl_t;

endpackage

FILE: hdl/afpd_lane.sv
module afpd_lane import afpd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lane_ctrl_t              ctrl,
  input  logic signed [SMP_W-1:0] sample,
  output logic                    done,
  output logic [SQ_W-1:0]         square
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_ABS  = 4'b0010,
    L_DIV  = 4'b0100,
    L_SQ   = 4'b1000
  } lane_st_t;

  lane_st_t                 state_r, state_nxt;
  logic signed [SMP_W-1:0]  win_r [WIN_DEPTH];
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [SUM_W-1:0]  old_ext, new_ext, neg_sum;
  logic [MAG_W-1:0]         dvd_r;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic [CNT_W:0]           trial, trial_sub;
  logic                     ge;
  logic [DIV_STEP_W-1:0]    step_r;
  logic [SQ_W-1:0]          sq_r;
  logic                     done_r;

  always_comb begin
    old_ext = ctrl.full ? {{(SUM_W-SMP_W){win_r[ctrl.slot][SMP_W-1]}}, win_r[ctrl.slot]}
                        : '0;
    new_ext = {{(SUM_W-SMP_W){sample[SMP_W-1]}}, sample};
    sum_nxt = sum_r - old_ext + new_ext;
    neg_sum = -sum_r;
  end

  always_comb begin
    trial     = {rem_r, dvd_r[MAG_W-1]};
    trial_sub = trial - {1'b0, ctrl.divisor};
    ge        = (trial >= {1'b0, ctrl.divisor});
    rem_nxt   = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      L_IDLE: if (ctrl.start) state_nxt = L_ABS;
      L_ABS:  state_nxt = L_DIV;
      L_DIV:  if (step_r == '0) state_nxt = L_SQ;
      L_SQ:   state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      sum_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == L_SQ);
      if (state_r == L_IDLE && ctrl.start) sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == L_IDLE && ctrl.start) win_r[ctrl.slot] <= sample;
    case (state_r)
      L_ABS: begin
        dvd_r  <= sum_r[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_r[MAG_W-1:0];
        rem_r  <= '0;
        step_r <= DIV_STEP_W'(MAG_W - 1);
      end
      L_DIV: begin
        dvd_r  <= {dvd_r[MAG_W-2:0], ge};
        rem_r  <= rem_nxt;
        step_r <= step_r - 1'b1;
      end
      L_SQ: sq_r <= dvd_r[AVG_W-1:0] * dvd_r[AVG_W-1:0];
      default: ;
    endcase
  end

  assign done   = done_r;
  assign square = sq_r;

endmodule

FILE: hdl/afpd_isqrt.sv
module afpd_isqrt import afpd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic                   busy_r;
  logic                   done_r;
  logic [ROOT_STEP_W-1:0] step_r;
  logic [RAD_W-1:0]       op_r;
  logic [ROOT_REM_W-1:0]  rem_r, rem_sh, trial;
  logic [ROOT_W-1:0]      root_r;
  logic                   ge;

  always_comb begin
    rem_sh = {rem_r[ROOT_REM_W-3:0], op_r[RAD_W-1:RAD_W-2]};
    trial  = {root_r, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      step_r <= ROOT_STEP_W'(ROOT_W - 1);
    end else if (busy_r) begin
      op_r   <= {op_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], ge};
      step_r <= step_r - 1'b1;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: hdl/accel_flight_phase_detector.sv
// Channel  Handshake           Payload
// in       in_valid/in_stall   in_accel_x_mg, in_accel_y_mg, in_accel_z_mg
// out      out_valid/out_stall out_magnitude_mg, out_*_seen, out_phase_event,
//                              out_reinit_request
// cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// An accepted sample passes the axis lanes (bit-serial divide by the fill
// count, one bit per cycle), the square root unit (one root bit per cycle),
// then the phase update into the result register. A new sample is accepted
// once the last one is registered, even while out_stall holds that result;
// a result still stalled when the next one is ready holds the block. rst_n
// is synchronous; it clears window sums, fill count, slot, run counters and
// flags and loads the register defaults. cfg_ready is always high.
module accel_flight_phase_detector import afpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [SMP_W-1:0] in_accel_x_mg,
  input  logic signed [SMP_W-1:0] in_accel_y_mg,
  input  logic signed [SMP_W-1:0] in_accel_z_mg,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ROOT_W-1:0]     out_magnitude_mg,
  output logic                  out_liftoff_seen,
  output logic                  out_zero_g_seen,
  output logic                  out_descent_seen,
  output logic [1:0]            out_phase_event,
  output logic                  out_reinit_request,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LANE = 4'b0010,
    S_ROOT = 4'b0100,
    S_DONE = 4'b1000
  } top_st_t;

  top_st_t           state_r, state_nxt;
  logic [THR_W-1:0]  lift_thr_r, zg_max_r, desc_thr_r, flat_thr_r;
  logic [RUN_W-1:0]  sustain_r, flat_lim_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  fill_r;
  logic              full;
  logic [RUN_W-1:0]  lift_run_r, zg_run_r, desc_run_r, flat_run_r;
  logic [RUN_W-1:0]  lift_run_nxt, zg_run_nxt, desc_run_nxt, flat_run_nxt;
  logic [2:0]        flags_r, flags_nxt;
  logic [1:0]        event_nxt;
  logic              reinit_nxt;
  logic              in_acc, out_free, out_load;
  lane_ctrl_t        lctrl;
  logic [2:0]        lane_done;
  logic [SQ_W-1:0]   sq_x, sq_y, sq_z;
  logic [RAD_W-1:0]  sq_sum;
  logic              root_done;
  logic [ROOT_W-1:0] mag;

  logic              out_valid_r;
  logic [ROOT_W-1:0] out_mag_r;
  logic [2:0]        out_flags_r;
  logic [1:0]        out_event_r;
  logic              out_reinit_r;

  function automatic logic [RUN_W-1:0] bump(input logic [RUN_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_DONE) && out_free;
  assign full      = (fill_r == CNT_W'(WIN_DEPTH));

  always_comb begin
    lctrl.start   = in_acc;
    lctrl.full    = full;
    lctrl.slot    = slot_r;
    lctrl.divisor = fill_r;
  end

  afpd_lane u_lane_x (
    .clk(clk), .rst_n(rst_n), .ctrl(lctrl), .sample(in_accel_x_mg),
    .done(lane_done[0]), .square(sq_x)
  );
  afpd_lane u_lane_y (
    .clk(clk), .rst_n(rst_n), .ctrl(lctrl), .sample(in_accel_y_mg),
    .done(lane_done[1]), .square(sq_y)
  );
  afpd_lane u_lane_z (
    .clk(clk), .rst_n(rst_n), .ctrl(lctrl), .sample(in_accel_z_mg),
    .done(lane_done[2]), .square(sq_z)
  );

  assign sq_sum = sq_x + sq_y + sq_z;

  afpd_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n),
    .start((state_r == S_LANE) && (&lane_done)),
    .radicand(sq_sum),
    .done(root_done), .root(mag)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_LANE;
      S_LANE: if (&lane_done) state_nxt = S_ROOT;
      S_ROOT: if (root_done) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    flags_nxt    = flags_r;
    event_nxt    = EV_NONE;
    zg_run_nxt   = zg_run_r;
    desc_run_nxt = desc_run_r;
    reinit_nxt   = 1'b0;

    lift_run_nxt = (mag >= lift_thr_r) ? bump(lift_run_r) : '0;
    if (!flags_nxt[0] && lift_run_nxt >= sustain_r) begin
      flags_nxt[0] = 1'b1;
      event_nxt    = EV_LIFTOFF;
    end
    if (flags_nxt[0] && !flags_nxt[1]) begin
      zg_run_nxt = (mag <= zg_max_r) ? bump(zg_run_r) : '0;
      if (zg_run_nxt >= sustain_r) begin
        flags_nxt[1] = 1'b1;
        event_nxt    = EV_ZERO_G;
      end
    end
    if (flags_nxt[1] && !flags_nxt[2]) begin
      desc_run_nxt = (mag >= desc_thr_r) ? bump(desc_run_r) : '0;
      if (desc_run_nxt >= sustain_r) begin
        flags_nxt[2] = 1'b1;
        event_nxt    = EV_DESCENT;
      end
    end

    if (mag < flat_thr_r) begin
      flat_run_nxt = bump(flat_run_r);
      if (flat_run_nxt > flat_lim_r) begin
        reinit_nxt   = 1'b1;
        flat_run_nxt = '0;
      end
    end else begin
      flat_run_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lift_thr_r  <= RST_LIFTOFF_THR;
      zg_max_r    <= RST_ZG_CEIL;
      desc_thr_r  <= RST_DESCENT_THR;
      sustain_r   <= RST_SUSTAIN;
      flat_thr_r  <= RST_FLAT_THR;
      flat_lim_r  <= RST_FLAT_LIMIT;
      slot_r      <= '0;
      fill_r      <= '0;
      lift_run_r  <= '0;
      zg_run_r    <= '0;
      desc_run_r  <= '0;
      flat_run_r  <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_LIFTOFF_THR: lift_thr_r <= cfg_data[THR_W-1:0];
          CFG_ZG_CEIL:     zg_max_r   <= cfg_data[THR_W-1:0];
          CFG_DESCENT_THR: desc_thr_r <= cfg_data[THR_W-1:0];
          CFG_SUSTAIN:     sustain_r  <= cfg_data[RUN_W-1:0];
          CFG_FLAT_THR:    flat_thr_r <= cfg_data[THR_W-1:0];
          CFG_FLAT_LIMIT:  flat_lim_r <= cfg_data[RUN_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        slot_r <= (slot_r == SLOT_W'(WIN_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        if (!full) fill_r <= fill_r + 1'b1;
      end
      if (out_load) begin
        lift_run_r  <= lift_run_nxt;
        zg_run_r    <= zg_run_nxt;
        desc_run_r  <= desc_run_nxt;
        flat_run_r  <= flat_run_nxt;
        flags_r     <= flags_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mag_r    <= mag;
      out_flags_r  <= flags_nxt;
      out_event_r  <= event_nxt;
      out_reinit_r <= reinit_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_magnitude_mg   = out_mag_r;
  assign out_liftoff_seen   = out_flags_r[0];
  assign out_zero_g_seen    = out_flags_r[1];
  assign out_descent_seen   = out_flags_r[2];
  assign out_phase_event    = out_event_r;
  assign out_reinit_request = out_reinit_r;

endmodule

FILE: tb/tb_accel_flight_phase_detector.sv
`timescale 1ns / 100ps

module tb_accel_flight_phase_detector;
  import afpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_VOID_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_VOID_HI = 3'd7;

  typedef struct packed {
    logic [ROOT_W-1:0] mag;
    logic              liftoff;
    logic              zero_g;
    logic              descent;
    logic [1:0]        phase_ev;
    logic              reinit;
  } reading_t;

  typedef enum {STIM_NOISE, STIM_QUIET, STIM_FLIGHT} stim_t;
  typedef enum {SEG_GROUND, SEG_BOOST, SEG_COAST, SEG_DESCENT, SEG_LANDING, SEG_NOISE} seg_t;

  class flight_log_checker;
    int liftoff_thr, zg_ceiling, descent_thr, sustain, flat_thr, flat_limit;
    int x_win[WIN_DEPTH];
    int y_win[WIN_DEPTH];
    int z_win[WIN_DEPTH];
    int x_sum, y_sum, z_sum;
    int slot, fill;
    int liftoff_run, zero_g_run, descent_run, flat_run;
    logic [2:0] flags;
    reading_t expected_readings[$];
    int mismatches;

    function new();
      liftoff_thr = int'(RST_LIFTOFF_THR);
      zg_ceiling  = int'(RST_ZG_CEIL);
      descent_thr = int'(RST_DESCENT_THR);
      sustain     = int'(RST_SUSTAIN);
      flat_thr    = int'(RST_FLAT_THR);
      flat_limit  = int'(RST_FLAT_LIMIT);
      foreach (x_win[i]) begin
        x_win[i] = 0;
        y_win[i] = 0;
        z_win[i] = 0;
      end
      x_sum = 0;
      y_sum = 0;
      z_sum = 0;
      slot = 0;
      fill = 0;
      liftoff_run = 0;
      zero_g_run = 0;
      descent_run = 0;
      flat_run = 0;
      flags = '0;
      mismatches = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LIFTOFF_THR: liftoff_thr = int'(data[THR_W-1:0]);
        CFG_ZG_CEIL:     zg_ceiling  = int'(data[THR_W-1:0]);
        CFG_DESCENT_THR: descent_thr = int'(data[THR_W-1:0]);
        CFG_SUSTAIN:     sustain     = int'(data[RUN_W-1:0]);
        CFG_FLAT_THR:    flat_thr    = int'(data[THR_W-1:0]);
        CFG_FLAT_LIMIT:  flat_limit  = int'(data[RUN_W-1:0]);
        default: ;
      endcase
    endfunction

    function int saturate_inc(int c);
      return (c < 255) ? c + 1 : 255;
    endfunction

    function int floor_root(longint unsigned v);
      longint unsigned trial;
      int root;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
        trial = longint'(root | (1 << b));
        if (trial * trial <= v) root = int'(trial);
      end
      return root;
    endfunction

    function void log_sample(logic signed [SMP_W-1:0] ax, logic signed [SMP_W-1:0] ay,
                             logic signed [SMP_W-1:0] az);
      reading_t r;
      int xa, ya, za, mag;
      longint unsigned radicand;
      r = '0;
      if (fill >= WIN_DEPTH) begin
        x_sum -= x_win[slot];
        y_sum -= y_win[slot];
        z_sum -= z_win[slot];
      end else begin
        fill++;
      end
      x_win[slot] = int'(ax);
      y_win[slot] = int'(ay);
      z_win[slot] = int'(az);
      x_sum += x_win[slot];
      y_sum += y_win[slot];
      z_sum += z_win[slot];
      slot = (slot + 1) % WIN_DEPTH;

      xa = x_sum / fill;
      ya = y_sum / fill;
      za = z_sum / fill;
      radicand = longint'(xa) * xa + longint'(ya) * ya + longint'(za) * za;
      mag = floor_root(radicand);
      r.mag = mag[ROOT_W-1:0];
      r.phase_ev = EV_NONE;

      liftoff_run = (mag >= liftoff_thr) ? saturate_inc(liftoff_run) : 0;
      if (!flags[0] && liftoff_run >= sustain) begin
        flags[0] = 1'b1;
        r.phase_ev = EV_LIFTOFF;
      end
      if (flags[0] && !flags[1]) begin
        zero_g_run = (mag <= zg_ceiling) ? saturate_inc(zero_g_run) : 0;
        if (zero_g_run >= sustain) begin
          flags[1] = 1'b1;
          r.phase_ev = EV_ZERO_G;
        end
      end
      if (flags[1] && !flags[2]) begin
        descent_run = (mag >= descent_thr) ? saturate_inc(descent_run) : 0;
        if (descent_run >= sustain) begin
          flags[2] = 1'b1;
          r.phase_ev = EV_DESCENT;
        end
      end

      if (mag < flat_thr) begin
        flat_run = saturate_inc(flat_run);
        if (flat_run > flat_limit) begin
          r.reinit = 1'b1;
          flat_run = 0;
        end
      end else begin
        flat_run = 0;
      end

      r.liftoff = flags[0];
      r.zero_g  = flags[1];
      r.descent = flags[2];
      expected_readings.push_back(r);
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reading: mag=%0d seen=%b%b%b ev=%0d reinit=%b",
                   got.mag, got.liftoff, got.zero_g, got.descent, got.phase_ev, got.reinit);
        return;
      end
      want = expected_readings.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("reading mismatch: exp mag=%0d seen=%b%b%b ev=%0d reinit=%b",
                   want.mag, want.liftoff, want.zero_g, want.descent, want.phase_ev,
                   want.reinit);
          $display("                  got mag=%0d seen=%b%b%b ev=%0d reinit=%b",
                   got.mag, got.liftoff, got.zero_g, got.descent, got.phase_ev, got.reinit);
        end
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [SMP_W-1:0] in_accel_x_mg;
  logic signed [SMP_W-1:0] in_accel_y_mg;
  logic signed [SMP_W-1:0] in_accel_z_mg;
  logic                    out_valid;
  logic                    out_stall;
  logic [ROOT_W-1:0]       out_magnitude_mg;
  logic                    out_liftoff_seen;
  logic                    out_zero_g_seen;
  logic                    out_descent_seen;
  logic [1:0]              out_phase_event;
  logic                    out_reinit_request;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  flight_log_checker sb;
  int          samples_sent = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;
  int unsigned cycle_count = 0;

  accel_flight_phase_detector dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_accel_x_mg     (in_accel_x_mg),
    .in_accel_y_mg     (in_accel_y_mg),
    .in_accel_z_mg     (in_accel_z_mg),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_magnitude_mg  (out_magnitude_mg),
    .out_liftoff_seen  (out_liftoff_seen),
    .out_zero_g_seen   (out_zero_g_seen),
    .out_descent_seen  (out_descent_seen),
    .out_phase_event   (out_phase_event),
    .out_reinit_request(out_reinit_request),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [SMP_W-1:0] near(int center, int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 16383) v = 16383;
    if (v < -16384) v = -16384;
    return v[SMP_W-1:0];
  endfunction

  function automatic logic [SMP_W-1:0] noise_axis();
    logic [SMP_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 15'h4000;
      1:       v = 15'h3FFF;
      2:       v = near(0, 60);
      default: v = SMP_W'($urandom_range(0, 32767));
    endcase
    return v;
  endfunction

  task automatic send_sample(logic [SMP_W-1:0] x, logic [SMP_W-1:0] y, logic [SMP_W-1:0] z);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_accel_x_mg = x;
    in_accel_y_mg = y;
    in_accel_z_mg = z;
    do @(posedge clk); while (in_stall);
    sb.log_sample(x, y, z);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.load_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    cfg_valid = 1'b0;
    while (sb.expected_readings.size() != 0) @(negedge clk);
  endtask

  task automatic send_segment(seg_t kind, int len);
    repeat (len) begin
      case (kind)
        SEG_GROUND:  send_sample(near(0, 40), near(0, 40), near(1000, 50));
        SEG_BOOST:   send_sample(near(0, 300), near(0, 300), near(6000, 5000));
        SEG_COAST:   send_sample(near(0, 80), near(0, 80), near(0, 80));
        SEG_DESCENT: send_sample(near(0, 200), near(0, 200), near(-3000, 1800));
        SEG_LANDING: send_sample(near(0, 20), near(0, 20), near(0, 20));
        default:     send_sample(noise_axis(), noise_axis(), noise_axis());
      endcase
    end
  endtask

  task automatic fly_profile();
    case ($urandom_range(0, 9))
      7: begin
        send_segment(SEG_GROUND, $urandom_range(1, 8));
        send_segment(SEG_BOOST, $urandom_range(1, 10));
        send_segment(SEG_DESCENT, $urandom_range(1, 10));
        send_segment(SEG_LANDING, $urandom_range(1, 16));
      end
      8: send_segment(SEG_NOISE, $urandom_range(1, 6));
      9: begin
        send_segment(SEG_BOOST, $urandom_range(1, 10));
        send_segment(SEG_LANDING, $urandom_range(1, 16));
      end
      default: begin
        send_segment(SEG_GROUND, $urandom_range(1, 8));
        send_segment(SEG_BOOST, $urandom_range(1, 10));
        send_segment(SEG_COAST, $urandom_range(1, 14));
        send_segment(SEG_DESCENT, $urandom_range(1, 10));
        send_segment(SEG_LANDING, $urandom_range(1, 16));
      end
    endcase
  endtask

  task automatic run_phase(int count, stim_t mode);
    int stop;
    stop = samples_sent + count;
    cfg_valid = 1'b0;
    send_burst = ($urandom_range(0, 3) == 0);
    recv_burst = ($urandom_range(0, 3) == 0);
    while (samples_sent < stop) begin
      case (mode)
        STIM_FLIGHT: fly_profile();
        STIM_QUIET:
          if ($urandom_range(0, 9) < 7) send_sample(near(0, 60), near(0, 60), near(0, 60));
          else send_segment(SEG_NOISE, 1);
        default:
          if ($urandom_range(0, 3) == 0) send_sample(near(0, 60), near(0, 60), near(0, 60));
          else send_segment(SEG_NOISE, 1);
      endcase
    end
  endtask

  initial begin
    reading_t got;
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.mag      = out_magnitude_mg;
        got.liftoff  = out_liftoff_seen;
        got.zero_g   = out_zero_g_seen;
        got.descent  = out_descent_seen;
        got.phase_ev = out_phase_event;
        got.reinit   = out_reinit_request;
        sb.check_reading(got);
        stall_left = recv_burst ? 0 : $urandom_range(0, 5);
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      @(negedge clk);
      out_stall = (stall_left > 0);
    end
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_accel_x_mg = '0;
    in_accel_y_mg = '0;
    in_accel_z_mg = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LIFTOFF_THR;
    cfg_data = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // hold liftoff off while the extremes and the flat watchdog are exercised
    write_reg(CFG_LIFTOFF_THR, 15'd32767);
    cfg_valid = 1'b0;
    send_sample(15'h3FFF, 15'h3FFF, 15'h3FFF);
    send_sample(15'h4000, 15'h4000, 15'h4000);
    send_sample(15'h3FFF, 15'h4000, 15'h0000);
    send_sample(15'h4000, 15'h3FFF, 15'h7FFF);
    send_sample(15'h2AAA, 15'h5555, 15'h0001);
    send_sample(15'h5555, 15'h2AAA, 15'h7FFE);
    send_sample(15'h0000, 15'h3FFF, 15'h4000);
    send_sample(15'h7FFF, 15'h0001, 15'h7FFF);
    repeat (16) send_sample('0, '0, '0);

    settle();
    write_reg(CFG_SUSTAIN, 15'h00FF);
    write_reg(CFG_ZG_CEIL, 15'd0);
    write_reg(CFG_DESCENT_THR, 15'd0);
    write_reg(CFG_FLAT_THR, 15'd0);
    write_reg(CFG_FLAT_LIMIT, 15'd1);
    write_reg(CFG_VOID_LO, CFG_DATA_W'($urandom_range(0, 32767)));
    write_reg(CFG_VOID_HI, CFG_DATA_W'($urandom_range(0, 32767)));
    run_phase(150, STIM_NOISE);

    // every magnitude is flat, the watchdog saturates and never fires
    settle();
    write_reg(CFG_FLAT_THR, 15'd32767);
    write_reg(CFG_FLAT_LIMIT, 15'h7FFF);
    run_phase(300, STIM_NOISE);

    settle();
    write_reg(CFG_FLAT_THR, 15'd50);
    write_reg(CFG_FLAT_LIMIT, 15'h0101);
    run_phase(150, STIM_QUIET);

    // liftoff and zero-g both declared on the first sample
    settle();
    write_reg(CFG_SUSTAIN, 15'd1);
    write_reg(CFG_LIFTOFF_THR, 15'd0);
    write_reg(CFG_ZG_CEIL, 15'd32767);
    write_reg(CFG_DESCENT_THR, 15'd32767);
    run_phase(60, STIM_NOISE);

    settle();
    write_reg(CFG_SUSTAIN, 15'h7E03);
    write_reg(CFG_LIFTOFF_THR, 15'd1150);
    write_reg(CFG_ZG_CEIL, 15'd200);
    write_reg(CFG_DESCENT_THR, 15'd1200);
    write_reg(CFG_FLAT_THR, 15'd50);
    write_reg(CFG_FLAT_LIMIT, 15'd10);
    run_phase(250, STIM_FLIGHT);

    settle();
    write_reg(CFG_SUSTAIN, 15'd0);
    write_reg(CFG_FLAT_THR, 15'd100);
    write_reg(CFG_FLAT_LIMIT, 15'd0);
    run_phase(170, STIM_QUIET);

    settle();
    repeat (40) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
